>>> design/ring_cellular_automaton_rng_defines.svh
// Assertion helpers used by the checker file.
`ifndef RING_CELLULAR_AUTOMATON_RNG_DEFINES_SVH
`define RING_CELLULAR_AUTOMATON_RNG_DEFINES_SVH

// Checked outside reset.
`define RCARNG_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Checked at every edge, reset included.
`define RCARNG_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

>>> design/rcarng_pkg.sv
`timescale 1ns / 1ps

package rcarng_pkg;

  localparam int CELLS      = 64;
  localparam int CELL_IDX_W = $clog2(CELLS);
  localparam int LEN_W      = $clog2(CELLS + 1);
  localparam int RULE_W     = 32;
  localparam int GEN_W      = 8;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [RULE_W-1:0] RULE_DEFAULT = 32'd1436965290;
  localparam logic [GEN_W-1:0]  GEN_DEFAULT  = 8'd4;
  localparam logic [LEN_W-1:0]  MIN_CELLS    = 7'd5;
  localparam logic [LEN_W-1:0]  MAX_LEN      = LEN_W'(CELLS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RULE  = 2'd0,
    REG_GENS  = 2'd1,
    REG_CELLS = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef struct packed {
    logic load_ring;
    logic load_count;
    logic step;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic last_gen;
  } dp_status_t;

endpackage

>>> design/rcarng_if.sv
`timescale 1ns / 1ps

interface rcarng_cmd_if import rcarng_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [CELLS-1:0] load_value;

  modport source (output valid, op, load_value, input ready);
  modport sink   (input valid, op, load_value, output ready);
endinterface

interface rcarng_res_if import rcarng_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CELLS-1:0] ring_value;

  modport source (output valid, ring_value, input ready);
  modport sink   (input valid, ring_value, output ready);
endinterface

>>> design/rcarng_dp.sv
`timescale 1ns / 1ps

module rcarng_dp import rcarng_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [CELLS-1:0]      load_value,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  output logic [CELLS-1:0]      ring_value
);

  logic [RULE_W-1:0]     rule_word;
  logic [GEN_W-1:0]      gens_cfg;
  logic [LEN_W-1:0]      active_cells;
  logic [CELLS-1:0]      ring;
  logic [GEN_W-1:0]      count;
  logic [CELLS-1:0]      out_reg;

  logic [RULE_W-1:0]     rule_eff;
  logic [GEN_W-1:0]      gens_eff;
  logic [LEN_W-1:0]      len_eff;
  logic [CELL_IDX_W-1:0] n_m1;
  logic [CELL_IDX_W-1:0] n_m2;
  logic [CELLS-1:0]      len_mask;
  logic [CELLS-1:0]      ring_next;

  always_comb begin
    rule_eff = (rule_word == '0) ? RULE_DEFAULT : rule_word;
    gens_eff = (gens_cfg == '0) ? GEN_DEFAULT : gens_cfg;
    if (active_cells < MIN_CELLS) begin
      len_eff = MIN_CELLS;
    end else if (active_cells > MAX_LEN) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = active_cells;
    end
    n_m1 = CELL_IDX_W'(len_eff - LEN_W'(1));
    n_m2 = CELL_IDX_W'(len_eff - LEN_W'(2));
  end

  // One generation over the whole ring; wrap taps follow the active length.
  always_comb begin
    logic       l2, l1, c0, r1, r2;
    logic [4:0] nbhd;
    for (int i = 0; i < CELLS; i++) begin
      len_mask[i] = (LEN_W'(i) < len_eff);
      c0 = ring[i];
      l1 = (i == 0) ? ring[n_m1] : ring[CELL_IDX_W'((i + CELLS - 1) % CELLS)];
      if (i == 0) begin
        l2 = ring[n_m2];
      end else if (i == 1) begin
        l2 = ring[n_m1];
      end else begin
        l2 = ring[CELL_IDX_W'((i + CELLS - 2) % CELLS)];
      end
      if (CELL_IDX_W'(i) == n_m1) begin
        r1 = ring[0];
        r2 = ring[1];
      end else if (CELL_IDX_W'(i) == n_m2) begin
        r1 = ring[CELL_IDX_W'((i + 1) % CELLS)];
        r2 = ring[0];
      end else begin
        r1 = ring[CELL_IDX_W'((i + 1) % CELLS)];
        r2 = ring[CELL_IDX_W'((i + 2) % CELLS)];
      end
      nbhd = {l2, l1, c0, r1, r2};
      ring_next[i] = rule_eff[nbhd] & len_mask[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_word    <= RULE_DEFAULT;
      gens_cfg     <= GEN_DEFAULT;
      active_cells <= MAX_LEN;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_RULE:  rule_word    <= cfg_wdata[RULE_W-1:0];
        REG_GENS:  gens_cfg     <= cfg_wdata[GEN_W-1:0];
        REG_CELLS: active_cells <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring  <= '0;
      count <= '0;
    end else begin
      if (cmd.load_ring) begin
        ring <= load_value & len_mask;
      end else if (cmd.step) begin
        ring <= ring_next;
      end
      if (cmd.load_count) begin
        count <= gens_eff;
      end else if (cmd.step) begin
        count <= count - GEN_W'(1);
      end
    end
  end

  // Result register: the final generation goes straight out with its step; a load publishes the masked ring.
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_reg <= cmd.step ? ring_next : (ring & len_mask);
    end
  end

  assign status.last_gen = (count == GEN_W'(1));
  assign ring_value      = out_reg;

endmodule

>>> design/rcarng_ctrl.sv
`timescale 1ns / 1ps

module rcarng_ctrl import rcarng_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  logic       cmd_op,
  output logic       cmd_ready,
  output logic       res_valid,
  input  logic       res_ready,
  input  dp_status_t status,
  output dp_cmd_t    dp_cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !res_valid || res_ready;
  assign cmd_ready = (state == ST_IDLE);

  always_comb begin
    dp_cmd     = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd_op == OP_LOAD) begin
            dp_cmd.load_ring = 1'b1;
            state_next       = ST_FIN;
          end else begin
            dp_cmd.load_count = 1'b1;
            state_next        = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (!status.last_gen) begin
          dp_cmd.step = 1'b1;
        end else if (slot_free) begin
          dp_cmd.step    = 1'b1;
          dp_cmd.publish = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          dp_cmd.publish = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (dp_cmd.publish) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

>>> design/ring_cellular_automaton_rng.sv
`timescale 1ns / 1ps
// A load item copies the masked load value into the ring and publishes it from ST_FIN; an advance
// item runs G generations, G = effective generation count (default 4), and publishes the last one.
// One item in flight: the next item is accepted only once the result is published; the ring
// update unit computes one whole generation per cycle, but the last one waits for a free output register.
// A finished result sits in an output register while the next item is accepted.
// Reset (rst, synchronous): ring cleared, registers back to defaults, no clearing pass.
module ring_cellular_automaton_rng import rcarng_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  rcarng_cmd_if.sink            cmd,
  rcarng_res_if.source          result,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  rcarng_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_op    (cmd.op),
    .cmd_ready (cmd.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .status    (dp_status),
    .dp_cmd    (dp_cmd)
  );

  rcarng_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .load_value (cmd.load_value),
    .cmd        (dp_cmd),
    .status     (dp_status),
    .ring_value (result.ring_value)
  );

endmodule

>>> design/rcarng_chk.sv
`timescale 1ns / 1ps
`include "ring_cellular_automaton_rng_defines.svh"

module rcarng_chk import rcarng_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             cmd_valid,
  input logic             cmd_ready,
  input logic             res_valid,
  input logic             res_ready,
  input logic [CELLS-1:0] ring_value
);

  `RCARNG_ASSERT_ALWAYS(a_reset_clears_result, clk, rst |=> !res_valid, "result valid after reset")

  // one item in flight: an accepted item blocks the input until its result is out
  `RCARNG_ASSERT(a_single_item, clk, rst, (cmd_valid && cmd_ready) |=> !cmd_ready, "input not blocked")

  `RCARNG_ASSERT(a_res_hold, clk, rst, (res_valid && !res_ready) |=> res_valid, "result dropped")

  `RCARNG_ASSERT(a_res_stable, clk, rst, (res_valid && !res_ready) |=> $stable(ring_value), "result changed")

endmodule

bind ring_cellular_automaton_rng rcarng_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .ring_value (result.ring_value)
);
